// ===== rtl/quadrant_mean_level_calibrator_defines.svh =====
// Assertion macros shared by the calibrator RTL.
// No dependencies; included by the top level.
`ifndef QUADRANT_MEAN_LEVEL_CALIBRATOR_DEFINES_SVH
`define QUADRANT_MEAN_LEVEL_CALIBRATOR_DEFINES_SVH

// Implication in the same cycle, masked while reset is low
`define QMLC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qmlc assertion failed");

// Implication in the next cycle, masked while reset is low
`define QMLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qmlc assertion failed");

`endif

// ===== rtl/qmlc_pkg.sv =====
// Types and constants for the quadrant mean level calibrator.
// No dependencies; used by quadrant_mean_level_calibrator.
package qmlc_pkg;

  // Item codes for the func field
  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_INIT  = 1'b1;

  // Level format: unsigned 8.4 fixed point
  localparam int LEVEL_W   = 12;
  localparam int FRAC_BITS = 4;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 12'd4080;
  localparam logic [LEVEL_W-1:0] LEVEL_MIN = 12'd0;

  // Divider: one quotient bit per step
  localparam int QUOT_W = LEVEL_W;
  localparam int STEP_W = $clog2(QUOT_W);

  typedef struct packed {
    logic       func;
    logic [5:0] cell_req;
    logic [7:0] pixel;
    logic       expect_black;
    logic       quad_end;
  } in_t;

  typedef struct packed {
    logic [5:0]         out_cell;
    logic [LEVEL_W-1:0] black_level;
    logic [LEVEL_W-1:0] white_level;
    logic [LEVEL_W-1:0] threshold;
  } out_t;

endpackage

// ===== rtl/quadrant_mean_level_calibrator.sv =====
// Quadrant mean level calibrator: per-quadrant mean, per-cell black/white levels.
// Depends on qmlc_pkg and quadrant_mean_level_calibrator_defines.svh.
//
//  port group   | dir | payload        | handshake
//  -------------+-----+----------------+----------------------
//  in_*         | in  | qmlc_pkg::in_t | in_valid / in_stall
//  out_*        | out | qmlc_pkg::out_t| out_valid / out_stall
//
// Non-last pixel: summed, input stays ready. Re-initialise: accept, result load.
// Last pixel: accept, 12 steps of the shared restoring divider
// (one quotient bit each), table update, result load.
// A result waits in the output register while out_stall is high; pixels are
// still taken meanwhile, but the next result holds the input until it loads.
// After reset a clearing pass fills every level table entry; input stalled.
`include "quadrant_mean_level_calibrator_defines.svh"

module quadrant_mean_level_calibrator #(
  parameter int CELLS           = 64,
  parameter int MAX_QUAD_PIXELS = 4096
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  qmlc_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output qmlc_pkg::out_t out_data
);
  import qmlc_pkg::*;

  localparam int CELL_AW = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CNT_W   = $clog2(MAX_QUAD_PIXELS + 1);
  localparam int SUM_W   = CNT_W + 8;
  localparam int DVD_W   = SUM_W + FRAC_BITS;
  localparam int ENT_W   = 2 * LEVEL_W;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_UPD,
    ST_EMIT
  } state_t;

  state_t               state_r;
  logic [CELL_AW-1:0]   clr_r;
  logic [SUM_W-1:0]     sum_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [CNT_W-1:0]     div_r;
  logic [CNT_W-1:0]     rem_r;
  logic [QUOT_W-1:0]    lo_r;
  logic [QUOT_W-1:0]    quot_r;
  logic [STEP_W-1:0]    step_r;
  logic [CELL_AW-1:0]   idx_r;
  logic [5:0]           cell_r;
  logic                 blk_r;
  logic [LEVEL_W-1:0]   blev_r;
  logic [LEVEL_W-1:0]   wlev_r;
  logic                 out_valid_r;
  out_t                 out_data_r;

  // Level table: {black, white} per cell
  logic [ENT_W-1:0]     mem [CELLS];
  logic [ENT_W-1:0]     mem_q_r;
  logic                 mem_we;
  logic [CELL_AW-1:0]   mem_waddr;
  logic [ENT_W-1:0]     mem_wdata;

  logic                 accept;
  logic [CELL_AW-1:0]   cell_idx;
  logic                 cell_ok;
  logic                 cnt_room;
  logic [SUM_W-1:0]     sum_nxt;
  logic [CNT_W-1:0]     cnt_nxt;
  logic [DVD_W-1:0]     dvd;
  logic [CNT_W:0]       trial;
  logic                 trial_ge;
  logic [CNT_W-1:0]     rem_nxt;
  logic [LEVEL_W-1:0]   tbl_black;
  logic [LEVEL_W-1:0]   tbl_white;
  logic [LEVEL_W-1:0]   blev_nxt;
  logic [LEVEL_W-1:0]   wlev_nxt;
  logic [LEVEL_W:0]     mid_sum;
  logic                 out_free;
  logic                 emit_go;
  logic [LEVEL_W:0]     mid_chk;

  // Input decode
  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign cell_idx = CELL_AW'(32'(in_data.cell_req));
  assign cell_ok  = (32'(in_data.cell_req) < 32'(CELLS));

  // Quadrant accumulation, this pixel included
  assign cnt_room = (cnt_r < CNT_W'(MAX_QUAD_PIXELS));
  assign sum_nxt  = cnt_room ? (sum_r + SUM_W'(in_data.pixel)) : sum_r;
  assign cnt_nxt  = cnt_room ? (cnt_r + CNT_W'(1)) : cnt_r;
  assign dvd      = {sum_nxt, {FRAC_BITS{1'b0}}};

  // One restoring division step
  assign trial    = {rem_r, lo_r[QUOT_W-1]};
  assign trial_ge = (trial >= {1'b0, div_r});
  assign rem_nxt  = trial_ge ? CNT_W'(trial - {1'b0, div_r}) : CNT_W'(trial);

  // Table update: black rises, white falls
  assign tbl_black = mem_q_r[ENT_W-1:LEVEL_W];
  assign tbl_white = mem_q_r[LEVEL_W-1:0];
  always_comb begin
    blev_nxt = tbl_black;
    wlev_nxt = tbl_white;
    if (blk_r) begin
      if (quot_r > tbl_black) blev_nxt = quot_r;
    end else begin
      if (quot_r < tbl_white) wlev_nxt = quot_r;
    end
  end

  assign mid_sum  = {1'b0, blev_r} + {1'b0, wlev_r};
  assign out_free = !out_valid_r || !out_stall;
  assign emit_go  = (state_r == ST_EMIT) && out_free;

  // Table write port mux
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = {blev_nxt, wlev_nxt};
    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = {LEVEL_MIN, LEVEL_MAX};
      end
      ST_IDLE: begin
        mem_we    = accept && (in_data.func == FUNC_INIT) && cell_ok;
        mem_waddr = cell_idx;
        mem_wdata = {LEVEL_MIN, LEVEL_MAX};
      end
      ST_UPD: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Level table storage
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      mem_q_r <= mem[cell_idx];
    end
  end

  // Sequencer, accumulator, divider and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      sum_r       <= '0;
      cnt_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + CELL_AW'(1);
          if (clr_r == CELL_AW'(CELLS - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            idx_r  <= cell_idx;
            cell_r <= in_data.cell_req;
            blk_r  <= in_data.expect_black;
            if (in_data.func == FUNC_INIT) begin
              blev_r <= LEVEL_MIN;
              wlev_r <= LEVEL_MAX;
              if (cell_ok) state_r <= ST_EMIT;
            end else if (in_data.quad_end) begin
              sum_r  <= '0;
              cnt_r  <= '0;
              div_r  <= cnt_nxt;
              rem_r  <= dvd[DVD_W-1:QUOT_W];
              lo_r   <= dvd[QUOT_W-1:0];
              step_r <= '0;
              if (cell_ok) state_r <= ST_DIV;
            end else begin
              sum_r <= sum_nxt;
              cnt_r <= cnt_nxt;
            end
          end
        end
        ST_DIV: begin
          rem_r  <= rem_nxt;
          lo_r   <= {lo_r[QUOT_W-2:0], 1'b0};
          quot_r <= {quot_r[QUOT_W-2:0], trial_ge};
          step_r <= step_r + STEP_W'(1);
          if (step_r == STEP_W'(QUOT_W - 1)) begin
            state_r <= ST_UPD;
          end
        end
        ST_UPD: begin
          blev_r  <= blev_nxt;
          wlev_r  <= wlev_nxt;
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_r            <= 1'b1;
            out_data_r.out_cell    <= cell_r;
            out_data_r.black_level <= blev_r;
            out_data_r.white_level <= wlev_r;
            out_data_r.threshold   <= mid_sum[LEVEL_W:1];
            state_r                <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Sum of the levels held in the output register; its upper bits are the midpoint
  assign mid_chk = {1'b0, out_data_r.black_level} + {1'b0, out_data_r.white_level};

  // Checks
  `QMLC_ASSERT_NOW(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CNT_W'(MAX_QUAD_PIXELS))
  `QMLC_ASSERT_NOW(a_mean_range, clk, rst_n, state_r == ST_UPD, quot_r <= LEVEL_MAX)
  `QMLC_ASSERT_NOW(a_out_mid, clk, rst_n, out_valid_r, out_data_r.threshold == mid_chk[LEVEL_W:1])
  `QMLC_ASSERT_NEXT(a_emit_loads, clk, rst_n, emit_go, out_valid_r && (state_r == ST_IDLE))

endmodule
